### hw/rtl/b32ae_pkg.sv
// ----------------------------------------------------------------------------
// b32ae_pkg
// Shared types, constants, microcode table and checksum helpers for the
// Bech32 address encoder.
// ----------------------------------------------------------------------------
package b32ae_pkg;

    localparam int PREFIX_MAX  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int PC_W        = 4;
    localparam int OP_W        = 4;
    localparam int CNT_W       = 4;

    // config register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_CHARS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_LENGTH = 2'd1;

    localparam logic [63:0] PREFIX_CHARS_RST  = 64'h6362;
    localparam logic [3:0]  PREFIX_LENGTH_RST = 4'd2;
    localparam logic [3:0]  PREFIX_LEN_MAX    = 4'(PREFIX_MAX);

    localparam logic [CNT_W-1:0] CK_LEN  = 4'd6;
    localparam logic [CNT_W-1:0] CK_LAST = 4'd5;

    localparam logic [6:0] CHAR_SEP = 7'h31;  // '1'
    localparam logic [6:0] CHAR_VER = 7'h71;  // 'q', witness version 0

    localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    localparam logic [29:0] GEN [5] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };

    // micro-ops
    localparam logic [OP_W-1:0] OP_WAIT     = 4'd0;
    localparam logic [OP_W-1:0] OP_FOLD_HI  = 4'd1;
    localparam logic [OP_W-1:0] OP_FOLD_Z   = 4'd2;
    localparam logic [OP_W-1:0] OP_FOLD_LO  = 4'd3;
    localparam logic [OP_W-1:0] OP_EMIT_PFX = 4'd4;
    localparam logic [OP_W-1:0] OP_EMIT_SEP = 4'd5;
    localparam logic [OP_W-1:0] OP_EMIT_VER = 4'd6;
    localparam logic [OP_W-1:0] OP_SYM      = 4'd7;
    localparam logic [OP_W-1:0] OP_PAD      = 4'd8;
    localparam logic [OP_W-1:0] OP_FOLD6    = 4'd9;
    localparam logic [OP_W-1:0] OP_EMIT_CK  = 4'd10;

    // jump conditions
    localparam logic [1:0] COND_ALWAYS = 2'd0;
    localparam logic [1:0] COND_INSIDE = 2'd1;
    localparam logic [1:0] COND_LAST   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      cond;
        logic [PC_W-1:0] tgt_true;
        logic [PC_W-1:0] tgt_false;
    } ucode_t;

    // sequencer -> datapath
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            done;
    } step_ctrl_t;

    // datapath -> sequencer
    typedef struct packed {
        logic cnt_eq_len;
        logic cnt_eq_ck;
        logic cnt_eq_ck_last;
        logic pend_ge5;
        logic pend_zero;
        logic out_free;
        logic in_addr;
        logic last;
    } dp_status_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            4'd0:    w = '{OP_WAIT,     COND_INSIDE, 4'd7,  4'd1};
            4'd1:    w = '{OP_FOLD_HI,  COND_ALWAYS, 4'd2,  4'd2};
            4'd2:    w = '{OP_FOLD_Z,   COND_ALWAYS, 4'd3,  4'd3};
            4'd3:    w = '{OP_FOLD_LO,  COND_ALWAYS, 4'd4,  4'd4};
            4'd4:    w = '{OP_EMIT_PFX, COND_ALWAYS, 4'd5,  4'd5};
            4'd5:    w = '{OP_EMIT_SEP, COND_ALWAYS, 4'd6,  4'd6};
            4'd6:    w = '{OP_EMIT_VER, COND_ALWAYS, 4'd7,  4'd7};
            4'd7:    w = '{OP_SYM,      COND_LAST,   4'd8,  4'd0};
            4'd8:    w = '{OP_PAD,      COND_ALWAYS, 4'd9,  4'd9};
            4'd9:    w = '{OP_FOLD6,    COND_ALWAYS, 4'd10, 4'd10};
            4'd10:   w = '{OP_EMIT_CK,  COND_ALWAYS, 4'd0,  4'd0};
            default: w = '{OP_WAIT,     COND_ALWAYS, 4'd0,  4'd0};
        endcase
        return w;
    endfunction

    // one BCH polymod step
    function automatic logic [29:0] polymod_step(input logic [29:0] cs,
                                                 input logic [4:0]  v);
        logic [4:0]  top;
        logic [29:0] r;
        top = cs[29:25];
        r   = {cs[24:0], v};
        for (int j = 0; j < 5; j++) begin
            if (top[j])
            begin
                r = r ^ GEN[j];
            end
        end
        return r;
    endfunction

    function automatic logic [6:0] sym_char(input logic [4:0] v);
        return CHARSET[{~v, 3'b000} +: 7];
    endfunction

endpackage

### hw/rtl/b32ae_sequencer.sv
// ----------------------------------------------------------------------------
// b32ae_sequencer
// Step counter and microcode table; decides step completion and jumps.
// ----------------------------------------------------------------------------
module b32ae_sequencer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  b32ae_pkg::dp_status_t status,
    output b32ae_pkg::step_ctrl_t ctrl
);

    logic [b32ae_pkg::PC_W-1:0] pc_reg;
    logic [b32ae_pkg::PC_W-1:0] pc_next;
    b32ae_pkg::ucode_t          uw;
    logic                       done;
    logic                       cond_true;

    assign uw = b32ae_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        case (uw.op)
            b32ae_pkg::OP_WAIT:     done = in_valid;
            b32ae_pkg::OP_FOLD_HI:  done = status.cnt_eq_len;
            b32ae_pkg::OP_FOLD_Z:   done = 1'b1;
            b32ae_pkg::OP_FOLD_LO:  done = status.cnt_eq_len;
            b32ae_pkg::OP_EMIT_PFX: done = status.cnt_eq_len;
            b32ae_pkg::OP_EMIT_SEP: done = status.out_free;
            b32ae_pkg::OP_EMIT_VER: done = status.out_free;
            b32ae_pkg::OP_SYM:      done = !status.pend_ge5;
            b32ae_pkg::OP_PAD:      done = status.pend_zero || status.out_free;
            b32ae_pkg::OP_FOLD6:    done = status.cnt_eq_ck;
            b32ae_pkg::OP_EMIT_CK:  done = status.out_free && status.cnt_eq_ck_last;
            default:                done = 1'b1;
        endcase

        case (uw.cond)
            b32ae_pkg::COND_ALWAYS: cond_true = 1'b1;
            b32ae_pkg::COND_INSIDE: cond_true = status.in_addr;
            b32ae_pkg::COND_LAST:   cond_true = status.last;
            default:                cond_true = 1'b1;
        endcase

        pc_next = pc_reg;
        if (done)
        begin
            pc_next = cond_true ? uw.tgt_true : uw.tgt_false;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.op   = uw.op;
    assign ctrl.done = done;

endmodule

### hw/rtl/b32ae_datapath.sv
// ----------------------------------------------------------------------------
// b32ae_datapath
// Bit regrouping, checksum polymod, step counter and output word register.
// ----------------------------------------------------------------------------
module b32ae_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  b32ae_pkg::step_ctrl_t ctrl,
    input  logic                  in_valid,
    input  logic [7:0]            data_byte,
    input  logic                  final_byte,
    input  logic [63:0]           prefix_chars,
    input  logic [3:0]            prefix_len,
    output b32ae_pkg::dp_status_t status,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [6:0]            out_char,
    output logic                  end_of_address
);

    logic [11:0]                 acc_reg, acc_next;
    logic [3:0]                  pend_reg, pend_next;
    logic [29:0]                 cs_reg, cs_next;
    logic                        inside_reg, inside_next;
    logic                        last_reg, last_next;
    logic [b32ae_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic [6:0]                  out_char_reg, out_char_next;
    logic                        end_reg, end_next;

    logic                        out_free;
    logic                        emit;
    logic [7:0]                  pbyte;
    logic [3:0]                  pend_sub;
    logic [11:0]                 sym_shift;
    logic [4:0]                  sym_val;
    logic [11:0]                 pad_shift;
    logic [4:0]                  pad_val;

    assign out_free  = !out_valid_reg || !out_stall;
    assign pbyte     = prefix_chars[{cnt_reg[2:0], 3'b000} +: 8];
    assign pend_sub  = pend_reg - 4'd5;
    assign sym_shift = acc_reg >> pend_sub;
    assign sym_val   = sym_shift[4:0];
    assign pad_shift = acc_reg << (3'd5 - pend_reg[2:0]);
    assign pad_val   = pad_shift[4:0];

    assign status.cnt_eq_len     = (cnt_reg == prefix_len);
    assign status.cnt_eq_ck      = (cnt_reg == b32ae_pkg::CK_LEN);
    assign status.cnt_eq_ck_last = (cnt_reg == b32ae_pkg::CK_LAST);
    assign status.pend_ge5       = (pend_reg >= 4'd5);
    assign status.pend_zero      = (pend_reg == 4'd0);
    assign status.out_free       = out_free;
    assign status.in_addr        = inside_reg;
    assign status.last           = last_reg;

    always_comb
    begin
        acc_next      = acc_reg;
        pend_next     = pend_reg;
        cs_next       = cs_reg;
        inside_next   = inside_reg;
        last_next     = last_reg;
        cnt_next      = cnt_reg;
        emit          = 1'b0;
        out_char_next = out_char_reg;
        end_next      = end_reg;

        case (ctrl.op)
            b32ae_pkg::OP_WAIT:
            begin
                // the byte is regrouped right away; it does not touch the checksum
                if (in_valid)
                begin
                    acc_next  = {acc_reg[3:0], data_byte};
                    pend_next = pend_reg + 4'd8;
                    last_next = final_byte;
                end
            end
            b32ae_pkg::OP_FOLD_HI:
            begin
                if (ctrl.done)
                begin
                    cnt_next = '0;
                end
                else
                begin
                    cs_next  = b32ae_pkg::polymod_step(cs_reg, {2'b00, pbyte[7:5]});
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            b32ae_pkg::OP_FOLD_Z:
            begin
                cs_next = b32ae_pkg::polymod_step(cs_reg, 5'd0);
            end
            b32ae_pkg::OP_FOLD_LO:
            begin
                if (ctrl.done)
                begin
                    cnt_next = '0;
                end
                else
                begin
                    cs_next  = b32ae_pkg::polymod_step(cs_reg, pbyte[4:0]);
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            b32ae_pkg::OP_EMIT_PFX:
            begin
                if (ctrl.done)
                begin
                    cnt_next = '0;
                end
                else if (out_free)
                begin
                    emit          = 1'b1;
                    out_char_next = pbyte[6:0];
                    end_next      = 1'b0;
                    cnt_next      = cnt_reg + 4'd1;
                end
            end
            b32ae_pkg::OP_EMIT_SEP:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_char_next = b32ae_pkg::CHAR_SEP;
                    end_next      = 1'b0;
                end
            end
            b32ae_pkg::OP_EMIT_VER:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_char_next = b32ae_pkg::CHAR_VER;
                    end_next      = 1'b0;
                    cs_next       = b32ae_pkg::polymod_step(cs_reg, 5'd0);
                    inside_next   = 1'b1;
                end
            end
            b32ae_pkg::OP_SYM:
            begin
                // bits above pend_reg are stale but never reach a symbol
                if (status.pend_ge5 && out_free)
                begin
                    emit          = 1'b1;
                    out_char_next = b32ae_pkg::sym_char(sym_val);
                    end_next      = 1'b0;
                    cs_next       = b32ae_pkg::polymod_step(cs_reg, sym_val);
                    pend_next     = pend_sub;
                end
            end
            b32ae_pkg::OP_PAD:
            begin
                if (!status.pend_zero && out_free)
                begin
                    emit          = 1'b1;
                    out_char_next = b32ae_pkg::sym_char(pad_val);
                    end_next      = 1'b0;
                    cs_next       = b32ae_pkg::polymod_step(cs_reg, pad_val);
                end
            end
            b32ae_pkg::OP_FOLD6:
            begin
                if (ctrl.done)
                begin
                    cs_next  = cs_reg ^ 30'd1;
                    cnt_next = '0;
                end
                else
                begin
                    cs_next  = b32ae_pkg::polymod_step(cs_reg, 5'd0);
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            b32ae_pkg::OP_EMIT_CK:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_char_next = b32ae_pkg::sym_char(cs_reg[29:25]);
                    end_next      = status.cnt_eq_ck_last;
                    cs_next       = {cs_reg[24:0], 5'd0};
                    cnt_next      = cnt_reg + 4'd1;
                    if (status.cnt_eq_ck_last)
                    begin
                        cnt_next    = '0;
                        cs_next     = 30'd1;
                        acc_next    = '0;
                        pend_next   = '0;
                        inside_next = 1'b0;
                        last_next   = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pend_reg      <= '0;
            cs_reg        <= 30'd1;
            inside_reg    <= 1'b0;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            cs_reg        <= cs_next;
            inside_reg    <= inside_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        end_reg      <= end_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_char       = out_char_reg;
    assign end_of_address = end_reg;

    // between bytes the regrouper holds less than one symbol
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == b32ae_pkg::OP_WAIT) |-> (pend_reg < 4'd5))
        else $error("pending bits left over at word boundary");

    // outside an address the checksum and regrouper sit at their start values
    a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == b32ae_pkg::OP_WAIT && !inside_reg) |->
        (cs_reg == 30'd1 && pend_reg == 4'd0))
        else $error("address state not cleared");

    // the final checksum character closes the address
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && end_reg) |-> !inside_reg)
        else $error("address still open after last character");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= b32ae_pkg::PREFIX_LEN_MAX)
        else $error("step counter out of range");

endmodule

### hw/rtl/bech32_address_encoder.sv
// ----------------------------------------------------------------------------
// bech32_address_encoder
// Bech32 (witness version 0) address encoder: payload bytes in, address
// characters out, with prefix, separator, version and BCH checksum.
// ----------------------------------------------------------------------------
// A byte is taken only while the sequencer waits at its first step, and the
// output characters come from the microcoded datapath. A byte inside an
// address steps through accept, one or two symbols and loop exit. The first
// byte of an address also runs two polymod passes over the prefix with a zero
// fold between them, then the prefix characters, separator and version. The
// final byte adds a pad symbol when bits remain, six zero folds and six
// checksum characters. A stall on the output channel holds each character
// step. The polymod unit folds one 5-bit symbol per cycle while no character
// step is stalled. Configuration is taken at any time; the prefix is read
// during the first byte of each address.
module bech32_address_encoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [b32ae_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [b32ae_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        data_byte,
    input  logic                              final_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [6:0]                        out_char,
    output logic                              end_of_address
);

    logic [63:0]           prefix_chars_reg;
    logic [3:0]            prefix_length_reg;
    logic [3:0]            prefix_len;
    b32ae_pkg::step_ctrl_t ctrl;
    b32ae_pkg::dp_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_chars_reg  <= b32ae_pkg::PREFIX_CHARS_RST;
            prefix_length_reg <= b32ae_pkg::PREFIX_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == b32ae_pkg::CFG_PREFIX_CHARS)
            begin
                prefix_chars_reg <= cfg_data;
            end
            else if (cfg_index == b32ae_pkg::CFG_PREFIX_LENGTH)
            begin
                prefix_length_reg <= cfg_data[3:0];
            end
        end
    end

    assign prefix_len = (prefix_length_reg > b32ae_pkg::PREFIX_LEN_MAX) ?
                        b32ae_pkg::PREFIX_LEN_MAX : prefix_length_reg;

    assign in_stall = (ctrl.op != b32ae_pkg::OP_WAIT);

    b32ae_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .ctrl     (ctrl)
    );

    b32ae_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .in_valid       (in_valid),
        .data_byte      (data_byte),
        .final_byte     (final_byte),
        .prefix_chars   (prefix_chars_reg),
        .prefix_len     (prefix_len),
        .status         (status),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_char       (out_char),
        .end_of_address (end_of_address)
    );

endmodule
